// ===== sv/psb_pkg.sv =====
package psb_pkg;

  localparam int TIME_W = 64;
  localparam int PAT_W  = 16;
  localparam int IDX_W  = 4;
  localparam int SLOTS  = 16;

  typedef struct packed {
    logic [IDX_W-1:0]  channel_index;
    logic [TIME_W-1:0] fire_time_ns;
    logic              build_now;
  } in_word_t;

  typedef struct packed {
    logic [TIME_W-1:0] delta_ns;
    logic [PAT_W-1:0]  port_pattern;
    logic [IDX_W-1:0]  entry_number;
    logic              final_entry;
    logic              schedule_empty;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic wr_time;
    logic copy;
    logic sort;
    logic sort_odd;
    logic take_first;
    logic fold;
    logic advance;
    logic emit_final;
    logic emit_empty;
  } psb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic head_valid;
    logic delta_zero;
    logic out_free;
  } psb_status_t;

endpackage

// ===== sv/psb_ctrl.sv =====
module psb_ctrl import psb_pkg::*; #(
  parameter int CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_build,
  input  psb_status_t status,
  output logic        in_ready,
  output psb_cmd_t    cmd
);

  localparam int NCH = (CHANNELS < SLOTS) ? CHANNELS : SLOTS;
  localparam int CW  = $clog2(NCH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_SORT,
    ST_FIRST,
    ST_SCAN
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] pass_r, pass_nxt;

  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.wr_time = in_valid;
        if (in_valid && in_build) begin
          state_nxt = ST_COPY;
        end
      end
      ST_COPY: begin
        cmd.copy  = 1'b1;
        pass_nxt  = '0;
        state_nxt = ST_SORT;
      end
      ST_SORT: begin
        cmd.sort     = 1'b1;
        cmd.sort_odd = pass_r[0];
        pass_nxt     = pass_r + 1'b1;
        if (pass_r == CW'(NCH - 1)) begin
          state_nxt = ST_FIRST;
        end
      end
      ST_FIRST: begin
        if (!status.head_valid) begin
          if (status.out_free) begin
            cmd.emit_empty = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end else begin
          cmd.take_first = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.head_valid) begin
          if (status.delta_zero) begin
            cmd.fold = 1'b1;
          end else if (status.out_free) begin
            cmd.advance = 1'b1;
          end
        end else if (status.out_free) begin
          cmd.emit_final = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pass_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
    end
  end

endmodule

// ===== sv/psb_datapath.sv =====
module psb_datapath import psb_pkg::*; #(
  parameter int CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  in_word_t    in_word,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  psb_cmd_t    cmd,
  output psb_status_t status,
  input  logic        out_ready,
  output logic        out_valid,
  output out_word_t   out_word
);

  localparam int NCH = (CHANNELS < SLOTS) ? CHANNELS : SLOTS;
  localparam int IW  = $clog2(NCH);

  logic [PAT_W-1:0]  cfg_en_r, cfg_en_nxt;
  logic [TIME_W-1:0] chan_t_r [NCH];
  logic [TIME_W-1:0] chan_t_nxt [NCH];

  // sort lanes: time, enabled flag and channel of each slot
  logic [TIME_W-1:0] work_t_r [NCH];
  logic [TIME_W-1:0] work_t_nxt [NCH];
  logic [IW-1:0]     work_i_r [NCH];
  logic [IW-1:0]     work_i_nxt [NCH];
  logic [NCH-1:0]    work_v_r, work_v_nxt;

  logic [TIME_W-1:0] pend_t_r, pend_t_nxt;
  logic [PAT_W-1:0]  pend_p_r, pend_p_nxt;
  logic [TIME_W-1:0] prev_r, prev_nxt;
  logic [PAT_W-1:0]  acc_r, acc_nxt;
  logic [IDX_W-1:0]  ecnt_r, ecnt_nxt;

  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_word_r, out_word_nxt;

  logic [PAT_W-1:0]  head_bit;
  logic [TIME_W-1:0] head_delta;
  logic              shift;

  assign head_bit   = PAT_W'(1) << work_i_r[0];
  assign head_delta = work_t_r[0] - prev_r;
  assign shift      = cmd.take_first | cmd.fold | cmd.advance;

  assign status.head_valid = work_v_r[0];
  assign status.delta_zero = (work_t_r[0] == prev_r);
  assign status.out_free   = !out_valid_r || out_ready;

  always_comb begin
    cfg_en_nxt    = cfg_we ? cfg_wdata : cfg_en_r;
    chan_t_nxt    = chan_t_r;
    work_t_nxt    = work_t_r;
    work_i_nxt    = work_i_r;
    work_v_nxt    = work_v_r;
    pend_t_nxt    = pend_t_r;
    pend_p_nxt    = pend_p_r;
    prev_nxt      = prev_r;
    acc_nxt       = acc_r;
    ecnt_nxt      = ecnt_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;

    // indexes at or beyond the channel count are dropped
    if (cmd.wr_time && (32'(in_word.channel_index) < NCH)) begin
      chan_t_nxt[in_word.channel_index[IW-1:0]] = in_word.fire_time_ns;
    end

    if (cmd.copy) begin
      for (int k = 0; k < NCH; k++) begin
        work_t_nxt[k] = chan_t_r[k];
        work_i_nxt[k] = IW'(k);
        work_v_nxt[k] = cfg_en_r[k];
      end
    end

    // odd-even transposition pass; disabled slots sink to the end,
    // strict compare keeps equal times in channel order
    if (cmd.sort) begin
      for (int k = 0; k < NCH - 1; k++) begin
        if (((k & 1) == 1) == cmd.sort_odd) begin
          if ({!work_v_r[k], work_t_r[k]} > {!work_v_r[k+1], work_t_r[k+1]}) begin
            work_t_nxt[k]   = work_t_r[k+1];
            work_i_nxt[k]   = work_i_r[k+1];
            work_v_nxt[k]   = work_v_r[k+1];
            work_t_nxt[k+1] = work_t_r[k];
            work_i_nxt[k+1] = work_i_r[k];
            work_v_nxt[k+1] = work_v_r[k];
          end
        end
      end
    end

    if (shift) begin
      for (int k = 0; k < NCH - 1; k++) begin
        work_t_nxt[k] = work_t_r[k+1];
        work_i_nxt[k] = work_i_r[k+1];
        work_v_nxt[k] = work_v_r[k+1];
      end
      work_v_nxt[NCH-1] = 1'b0;
    end

    if (cmd.take_first) begin
      pend_t_nxt = work_t_r[0];
      pend_p_nxt = head_bit;
      prev_nxt   = work_t_r[0];
      acc_nxt    = '0;
      ecnt_nxt   = '0;
    end

    if (cmd.fold) begin
      pend_p_nxt = pend_p_r | head_bit;
    end

    if (cmd.advance) begin
      pend_t_nxt = head_delta;
      pend_p_nxt = head_bit;
      prev_nxt   = work_t_r[0];
      acc_nxt    = acc_r | pend_p_r;
      ecnt_nxt   = ecnt_r + 1'b1;
    end

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.advance || cmd.emit_final) begin
      out_valid_nxt               = 1'b1;
      out_word_nxt.delta_ns       = pend_t_r;
      out_word_nxt.port_pattern   = acc_r | pend_p_r;
      out_word_nxt.entry_number   = ecnt_r;
      out_word_nxt.final_entry    = cmd.emit_final;
      out_word_nxt.schedule_empty = 1'b0;
    end
    if (cmd.emit_empty) begin
      out_valid_nxt               = 1'b1;
      out_word_nxt                = '0;
      out_word_nxt.schedule_empty = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_en_r    <= '1;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NCH; k++) begin
        chan_t_r[k] <= '0;
      end
    end else begin
      cfg_en_r    <= cfg_en_nxt;
      out_valid_r <= out_valid_nxt;
      chan_t_r    <= chan_t_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_t_r   <= work_t_nxt;
    work_i_r   <= work_i_nxt;
    work_v_r   <= work_v_nxt;
    pend_t_r   <= pend_t_nxt;
    pend_p_r   <= pend_p_nxt;
    prev_r     <= prev_nxt;
    acc_r      <= acc_nxt;
    ecnt_r     <= ecnt_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== sv/pulse_schedule_builder_unit.sv =====
// Pulse schedule builder. Each input word stores the absolute firing time
// of one channel (times persist between loads; indexes at or above the
// channel count are ignored). A word with build_now set stores its time and
// then builds the schedule from the channels enabled in cfg_wdata's
// register: stable ascending sort by time, first entry absolute, later
// entries as deltas, zero deltas folded into the previous entry, and port
// patterns accumulated as a running OR. One output word per entry is sent,
// the last one with final_entry set; with no channel enabled a single word
// with schedule_empty set (other fields zero) is sent. Load words are taken back
// to back while idle. A build runs a copy step, N odd-even sort passes
// (N = min(CHANNELS,16)) over N sort lanes, then each sorted entry in turn
// through the single delta/fold unit, where emitting an entry waits while the
// output side stalls. in_ready is low for the whole build. The enable register
// may be written at any idle time.
module pulse_schedule_builder_unit import psb_pkg::*; #(
  parameter int CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_word,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  psb_cmd_t    cmd;
  psb_status_t status;

  // sequencer: load / copy / sort passes / delta-fold scan
  psb_ctrl #(
    .CHANNELS(CHANNELS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_build (in_word.build_now),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // channel times, sort lanes, pending entry and output register
  psb_datapath #(
    .CHANNELS(CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  // while loads are taken, only the closing word of a build can be pending
  a_idle_out_closing: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && out_valid) |-> (out_word.final_entry || out_word.schedule_empty))
    else $error("non-final schedule word pending while idle");

  // empty word carries zero fields
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.schedule_empty) |->
      (out_word.delta_ns == '0 && out_word.port_pattern == '0 &&
       out_word.entry_number == '0 && !out_word.final_entry))
    else $error("empty schedule word has nonzero fields");

  // every real entry drives at least one channel bit
  a_pattern_set: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.schedule_empty) |-> (out_word.port_pattern != '0))
    else $error("schedule entry with empty port pattern");

  // a build never starts the emit path in the same cycle as a load
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_time |-> !(cmd.advance || cmd.emit_final || cmd.emit_empty || cmd.sort))
    else $error("load overlaps build");

endmodule
